@@ hdl/tdpt_pkg.sv @@
// Package for the trial division prime tester: widths, register indexes,
// controller states and the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package tdpt_pkg;

    localparam int NUMBER_WIDTH = 32;
    localparam int DATA_W       = 32;
    localparam int CFG_IDX_W    = 4;
    localparam int BIT_CNT_W    = $clog2(DATA_W);
    localparam int SQ_W         = DATA_W + 2;

    localparam logic [DATA_W-1:0] NUMBER_MASK =
        (NUMBER_WIDTH >= DATA_W) ? '1 : DATA_W'((64'd1 << NUMBER_WIDTH) - 64'd1);

    localparam logic [CFG_IDX_W-1:0] CFG_START_ORDINAL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT   = CFG_IDX_W'(1);

    localparam logic [DATA_W-1:0] UPPER_LIMIT_RESET = '1;
    localparam logic [BIT_CNT_W-1:0] BIT_CNT_LAST   = BIT_CNT_W'(DATA_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_REMCHK,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        V_COMPOSITE,
        V_PRIME,
        V_BEYOND
    } t_verdict;

    typedef struct packed {
        logic load;
        logic start_div;
        logic div_step;
        logic next_div;
        logic finish;
        logic prime;
        logic beyond;
    } t_dp_cmd;

    typedef struct packed {
        logic beyond;
        logic below_two;
        logic sq_gt;
        logic div_last;
        logic rem_zero;
        logic out_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ hdl/tdpt_if.sv @@
// Valid/ready channel interfaces for candidate items, result items and register writes.
// Depends on tdpt_pkg.
`default_nettype none

interface tdpt_cand_if import tdpt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface tdpt_res_if import tdpt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              is_prime;
    logic [DATA_W-1:0] ordinal;
    logic              beyond_limit;

    modport source (output valid, output is_prime, output ordinal, output beyond_limit,
                    input ready);
    modport sink   (input valid, input is_prime, input ordinal, input beyond_limit,
                    output ready);
endinterface

interface tdpt_cfg_if import tdpt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/tdpt_ctrl.sv @@
// Controller of the prime tester: sequences limit check, divisor loop and result hand-off.
// Depends on tdpt_pkg.
`default_nettype none

module tdpt_ctrl import tdpt_pkg::*; (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state   r_state, n_state;
    t_verdict r_verdict, n_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_verdict <= V_COMPOSITE;
        end else begin
            r_state   <= n_state;
            r_verdict <= n_verdict;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_verdict = r_verdict;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.beyond) begin
                    n_state   = S_DONE;
                    n_verdict = V_BEYOND;
                end else if (i_sts.below_two) begin
                    n_state   = S_DONE;
                    n_verdict = V_COMPOSITE;
                end else if (i_sts.sq_gt) begin
                    n_state   = S_DONE;
                    n_verdict = V_PRIME;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_REMCHK;
                end
            end
            S_REMCHK: begin
                if (i_sts.rem_zero) begin
                    n_state   = S_DONE;
                    n_verdict = V_COMPOSITE;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_CHECK: begin
                o_cmd.start_div = !i_sts.beyond && !i_sts.below_two && !i_sts.sq_gt;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_REMCHK: begin
                o_cmd.next_div = !i_sts.rem_zero;
            end
            S_DONE: begin
                o_cmd.finish = !i_sts.out_busy;
                o_cmd.prime  = (r_verdict == V_PRIME);
                o_cmd.beyond = (r_verdict == V_BEYOND);
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/tdpt_dp.sv @@
// Datapath of the prime tester: candidate and divisor registers, bit-serial remainder unit,
// configuration registers, prime counter and output register. Depends on tdpt_pkg.
`default_nettype none

module tdpt_dp import tdpt_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire [DATA_W-1:0]     i_candidate,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [DATA_W-1:0]     i_cfg_data,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic                 o_is_prime,
    output logic [DATA_W-1:0]    o_ordinal,
    output logic                 o_beyond_limit
);

    logic [DATA_W-1:0]    r_cand;
    logic [DATA_W-1:0]    r_div;
    logic [SQ_W-1:0]      r_sq;
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_num;
    logic [BIT_CNT_W-1:0] r_cnt;
    logic [DATA_W-1:0]    r_upper_limit;
    logic [DATA_W-1:0]    r_prime_count;
    logic                 r_out_valid;
    logic                 r_is_prime;
    logic [DATA_W-1:0]    r_ordinal;
    logic                 r_beyond;

    logic [DATA_W:0]      rem_shift;
    logic                 rem_ge;
    logic [DATA_W-1:0]    n_rem;
    logic [DATA_W-1:0]    count_inc;

    assign rem_shift = {r_rem, r_num[DATA_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, r_div});
    assign n_rem     = rem_ge ? DATA_W'(rem_shift - {1'b0, r_div}) : rem_shift[DATA_W-1:0];
    assign count_inc = r_prime_count + DATA_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cand <= i_candidate & NUMBER_MASK;
            r_div  <= DATA_W'(2);
            r_sq   <= SQ_W'(4);
        end else if (i_cmd.next_div) begin
            if (r_div == DATA_W'(2)) begin
                r_div <= DATA_W'(3);
                r_sq  <= SQ_W'(9);
            end else begin
                r_div <= r_div + DATA_W'(2);
                r_sq  <= r_sq + {r_div, 2'b00} + SQ_W'(4);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_div) begin
            r_rem <= '0;
            r_num <= r_cand;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_num <= {r_num[DATA_W-2:0], 1'b0};
            r_cnt <= r_cnt + BIT_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_limit <= UPPER_LIMIT_RESET;
            r_prime_count <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_UPPER_LIMIT)) begin
                r_upper_limit <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == CFG_START_ORDINAL)) begin
                r_prime_count <= i_cfg_data;
            end else if (i_cmd.finish && i_cmd.prime) begin
                r_prime_count <= count_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_is_prime <= i_cmd.prime;
            r_beyond   <= i_cmd.beyond;
            r_ordinal  <= i_cmd.prime ? count_inc : r_prime_count;
        end
    end

    always_comb begin
        o_sts.beyond    = (r_cand > r_upper_limit);
        o_sts.below_two = (r_cand < DATA_W'(2));
        o_sts.sq_gt     = (r_sq > {2'b00, r_cand});
        o_sts.div_last  = (r_cnt == BIT_CNT_LAST);
        o_sts.rem_zero  = (r_rem == '0);
        o_sts.out_busy  = r_out_valid && !i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_is_prime     = r_is_prime;
    assign o_ordinal      = r_ordinal;
    assign o_beyond_limit = r_beyond;

endmodule

`default_nettype wire

@@ hdl/trial_division_prime_test.sv @@
// Trial division prime tester with a running prime counter. Each candidate item is checked
// against upper_limit, then divided by 2, 3, 5, 7, ... while divisor squared does not exceed it.
// The remainder unit works bit-serially through the candidate for each divisor, then the loop
// check follows; a prime tries k divisors, k being about sqrt(candidate) / 2, while a composite
// stops at its smallest factor. Items beyond the limit, below 2, or equal to 2 or 3 skip the
// remainder unit. One item is in work at a time; the next is taken while the previous result
// waits in the output register.
// Depends on tdpt_pkg, tdpt_if, tdpt_ctrl and tdpt_dp.
`default_nettype none

module trial_division_prime_test import tdpt_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    tdpt_cand_if.sink    i_cand,
    tdpt_res_if.source   o_res,
    tdpt_cfg_if.sink     i_cfg
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    assign i_cand.ready = in_ready;
    assign i_cfg.ready  = 1'b1;

    tdpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cand.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tdpt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_candidate    (i_cand.candidate),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_res.valid),
        .i_out_ready    (o_res.ready),
        .o_is_prime     (o_res.is_prime),
        .o_ordinal      (o_res.ordinal),
        .o_beyond_limit (o_res.beyond_limit)
    );

endmodule

`default_nettype wire

@@ test/tb_trial_division_prime_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for trial_division_prime_test: a scoreboard class predicts each result
// from accepted candidates and register writes, plain tasks drive the candidate and register channels
// and an always block drives result ready. Depends on tdpt_pkg, tdpt_if and the trial_division_prime_test RTL.

module tb_trial_division_prime_test;
    import tdpt_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 11;
    localparam int PHASE_ITEMS    = 150;
    localparam int LONG_HOLD      = 2000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic              prime;
        logic [DATA_W-1:0] ordinal;
        logic              beyond;
    } t_prime_result;

    class prime_scoreboard;
        logic [DATA_W-1:0] start_ordinal;
        logic [DATA_W-1:0] upper_limit;
        logic [DATA_W-1:0] prime_count;
        t_prime_result     awaited[$];
        int                mismatches;
        int                checked;
        int                noted;
        int                primes;
        int                beyond;
        int                writes;

        function new();
            start_ordinal = '0;
            upper_limit   = UPPER_LIMIT_RESET;
            prime_count   = '0;
            mismatches    = 0;
            checked       = 0;
            noted         = 0;
            primes        = 0;
            beyond        = 0;
            writes        = 0;
        endfunction

        function bit by_trial(logic [63:0] n);
            logic [63:0] d;
            if (n < 64'd2)
                return 1'b0;
            for (d = 64'd2; d <= n / d; d++) begin
                if (n % d == 64'd0)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index, logic [DATA_W-1:0] data);
            writes++;
            case (index)
                CFG_START_ORDINAL: begin
                    start_ordinal = data;
                    prime_count   = data;
                end
                CFG_UPPER_LIMIT: begin
                    upper_limit = data;
                end
                default: begin
                end
            endcase
        endfunction

        function void note_candidate(logic [DATA_W-1:0] candidate);
            t_prime_result     r;
            logic [DATA_W-1:0] c;
            c = candidate & NUMBER_MASK;
            r = '0;
            if (c > upper_limit) begin
                r.beyond = 1'b1;
                beyond++;
            end else if (by_trial(64'(c))) begin
                prime_count = prime_count + DATA_W'(1);
                r.prime     = 1'b1;
                primes++;
            end
            r.ordinal = prime_count;
            awaited.push_back(r);
            noted++;
        endfunction

        function void check_result(logic is_prime, logic [DATA_W-1:0] ordinal,
                                   logic beyond_limit);
            t_prime_result want;
            checked++;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("Result %0d arrived with none awaited", checked);
                    $display("    got prime=%0b ordinal=%0d beyond=%0b",
                             is_prime, ordinal, beyond_limit);
                end
                return;
            end
            want = awaited.pop_front();
            if (want.prime !== is_prime || want.ordinal !== ordinal
                    || want.beyond !== beyond_limit) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("Result %0d mismatch: expected prime=%0b ordinal=%0d beyond=%0b",
                             checked, want.prime, want.ordinal, want.beyond);
                    $display("    got prime=%0b ordinal=%0d beyond=%0b",
                             is_prime, ordinal, beyond_limit);
                end
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;
    int input_stalls   = 0;

    prime_scoreboard sb;

    tdpt_cand_if cand_if ();
    tdpt_res_if  res_if ();
    tdpt_cfg_if  cfg_if ();

    trial_division_prime_test DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cand  (cand_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready)
                sb.check_result(res_if.is_prime, res_if.ordinal, res_if.beyond_limit);
            if (cand_if.valid && !cand_if.ready && hold_left > 0)
                input_stalls++;
        end
    end

    task automatic send_candidate(input logic [DATA_W-1:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            cand_if.valid     <= 1'b0;
            cand_if.candidate <= DATA_W'($urandom);
            @(negedge i_clk);
        end
        cand_if.valid     <= 1'b1;
        cand_if.candidate <= c;
        @(posedge i_clk);
        while (!cand_if.ready)
            @(posedge i_clk);
        sb.note_candidate(c);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        sb.write_register(index, data);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input bit load_start, input logic [DATA_W-1:0] start,
                             input logic [DATA_W-1:0] limit);
        logic [CFG_IDX_W-1:0] spare;
        spare = CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, int'(CFG_UPPER_LIMIT) + 1));
        wait_drained();
        if (load_start)
            write_register(CFG_START_ORDINAL, start);
        write_register(CFG_UPPER_LIMIT, limit);
        write_register(spare, DATA_W'($urandom));
        cfg_if.valid <= 1'b0;
    endtask

    // small values dominate so that the trial loop stays short; large ones are even or beyond
    function automatic logic [DATA_W-1:0] pick_candidate(logic [DATA_W-1:0] limit);
        int unsigned       r;
        logic [DATA_W-1:0] v;
        r = $urandom_range(99);
        if (r < 8)
            v = $urandom_range(3);
        else if (r < 55)
            v = $urandom_range(255);
        else if (r < 78)
            v = $urandom_range(4095, 256);
        else if (r < 86)
            v = $urandom_range(65535, 4096);
        else if (r < 94 || limit == '1)
            v = $urandom & ~32'd1;
        else
            v = $urandom_range(32'hFFFF_FFFF, limit + 1);
        return v;
    endfunction

    task automatic run_phase(input int send_pct, input int recv_pct, input bit press);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (press)
            hold_requests++;
        repeat (PHASE_ITEMS) send_candidate(pick_candidate(sb.upper_limit));
        cand_if.valid <= 1'b0;
    endtask

    initial begin
        sb = new();
        cand_if.valid     = 1'b0;
        cand_if.candidate = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = '0;
        cfg_if.data       = '0;
        res_if.ready      = 1'b0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: edges of the trial loop and the field extremes
        send_candidate(32'd0);
        send_candidate(32'd1);
        send_candidate(32'd2);
        send_candidate(32'd3);
        send_candidate(32'd4);
        send_candidate(32'd9);
        send_candidate(32'd25);
        send_candidate(32'd97);
        send_candidate(32'd100);
        send_candidate(32'd63001);
        send_candidate(32'd65521);
        send_candidate(32'd1048573);
        send_candidate(32'hFFFF_FFFF);
        send_candidate(32'hFFFF_FFFE);
        send_candidate(32'h8000_0000);
        cand_if.valid <= 1'b0;

        // counter wraps past the top
        configure(1'b1, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_candidate(32'd5);
        send_candidate(32'd7);
        send_candidate(32'd11);
        cand_if.valid <= 1'b0;

        configure(1'b1, 32'h0000_0000, 32'h0000_0000);
        send_candidate(32'd0);
        send_candidate(32'd1);
        send_candidate(32'hFFFF_FFFB);
        cand_if.valid <= 1'b0;

        // candidate equal to the limit is tested, one above is not
        configure(1'b1, 32'd12345, 32'd100);
        send_candidate(32'd97);
        send_candidate(32'd100);
        send_candidate(32'd101);
        send_candidate(32'd89);
        cand_if.valid <= 1'b0;

        configure(1'b1, '0, '1);
        run_phase(0, 0, 1'b1);
        configure(1'b1, 32'hFFFF_FFF0, DATA_W'($urandom_range(65535, 1000)));
        run_phase(45, 0, 1'b0);
        configure(1'b0, '0, DATA_W'($urandom));
        run_phase(0, 45, 1'b0);
        configure(1'b1, DATA_W'($urandom), DATA_W'($urandom_range(300)));
        run_phase(12, 12, 1'b0);

        wait_drained();

        $display("Summary: %0d candidates, %0d results checked, %0d primes counted,",
                 sb.noted, sb.checked, sb.primes);
        $display("    %0d beyond limit, %0d mismatches, %0d register writes,",
                 sb.beyond, sb.mismatches, sb.writes);
        $display("    four idle profiles, input held off %0d cycles behind a blocked output",
                 input_stalls);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #48_000_000;
        $display("Run timed out with %0d results outstanding", sb.pending());
        $display("Regression FAIL");
        $finish;
    end

endmodule
